// ===== rtl/mrq_pkg.sv =====
// Package for the multi-reader ring queue block: field widths, codes,
// controller states and the command and status bundles.
// No dependencies; every other file but mrq_ram imports it.
package mrq_pkg;

    localparam int NUM_QUEUES_DEF    = 8;
    localparam int MAX_DEPTH_DEF     = 16;
    localparam int MAX_CONSUMERS_DEF = 4;

    localparam int FUNC_W      = 2;
    localparam int QIDX_W      = 3;
    localparam int CIDX_W      = 2;
    localparam int SEQ_W       = 16;
    localparam int STATUS_W    = 3;
    localparam int RC_W        = 3;
    localparam int FILL_OUT_W  = 5;
    localparam int CONS_CFG_W  = 3;
    localparam int DEPTH_CFG_W = 5;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CONS_CFG_W-1:0]  CONS_RESET  = 3'd3;
    localparam logic [DEPTH_CFG_W-1:0] DEPTH_RESET = 5'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CONSUMERS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH     = 1'd1;

    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED,
        ST_READ_NEW,
        ST_EMPTY,
        ST_ALREADY,
        ST_OVERFLOW,
        ST_HALTED,
        ST_STOPPED
    } mrq_status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_MOD,
        S_SLOTTED,
        S_ENTRY
    } mrq_state_t;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic mod_start;
        logic mod_step;
        logic slot_from_mod;
        logic rd_entry;
        logic do_push;
        logic do_fail;
        logic do_read;
    } mrq_cmd_t;

    typedef struct packed {
        logic halted;
        logic is_push;
        logic is_stop;
        logic full;
        logic empty;
        logic needs_long;
        logic mod_done;
        logic out_busy;
        logic clear_done;
    } mrq_sts_t;

endpackage

// ===== rtl/mrq_item_if.sv =====
// Input channel of the multi-reader ring queue block.
// Depends on mrq_pkg for the field widths.
interface mrq_item_if import mrq_pkg::*;;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [QIDX_W-1:0] queue_index;
    logic [CIDX_W-1:0] consumer_index;
    logic [SEQ_W-1:0]  seq_value;

    modport source (output valid, func, queue_index, consumer_index, seq_value,
                    input ready);
    modport sink (input valid, func, queue_index, consumer_index, seq_value,
                  output ready);
endinterface

// ===== rtl/mrq_result_if.sv =====
// Result channel of the multi-reader ring queue block.
// Depends on mrq_pkg for the field widths.
interface mrq_result_if import mrq_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SEQ_W-1:0]      seq_out;
    logic [RC_W-1:0]       read_count;
    logic                  removed;
    logic [FILL_OUT_W-1:0] queue_fill;

    modport source (output valid, status, seq_out, read_count, removed, queue_fill,
                    input ready);
    modport sink (input valid, status, seq_out, read_count, removed, queue_fill,
                  output ready);
endinterface

// ===== rtl/mrq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mrq_ctrl.sv =====
// Controller of the multi-reader ring queue block: sequences clearing, lookup,
// slot remainder, entry read and result hand-off. Depends on mrq_pkg.
module mrq_ctrl import mrq_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  mrq_sts_t sts,
    output mrq_cmd_t cmd
);

    mrq_state_t state_reg;
    mrq_state_t state_next;
    logic       terminal;

    assign terminal = sts.halted || sts.is_stop || (sts.is_push && sts.full)
                      || (!sts.is_push && !sts.is_stop && sts.empty);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (terminal || (sts.is_push && !sts.needs_long))
                begin
                    if (!sts.out_busy)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (sts.needs_long)
                begin
                    state_next = S_MOD;
                end
                else
                begin
                    state_next = S_ENTRY;
                end
            end
            S_MOD:
            begin
                if (sts.mod_done)
                begin
                    state_next = S_SLOTTED;
                end
            end
            S_SLOTTED:
            begin
                if (sts.is_push)
                begin
                    if (!sts.out_busy)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_ENTRY;
                end
            end
            S_ENTRY:
            begin
                if (!sts.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            S_IDLE:
            begin
                item_ready = 1'b1;
                cmd.accept = item_valid;
            end
            S_LOOKUP:
            begin
                if (terminal)
                begin
                    cmd.do_fail = !sts.out_busy;
                end
                else if (sts.needs_long)
                begin
                    cmd.mod_start = 1'b1;
                end
                else if (sts.is_push)
                begin
                    cmd.do_push = !sts.out_busy;
                end
                else
                begin
                    cmd.rd_entry = 1'b1;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
            end
            S_SLOTTED:
            begin
                cmd.slot_from_mod = 1'b1;
                if (sts.is_push)
                begin
                    cmd.do_push = !sts.out_busy;
                end
                else
                begin
                    cmd.rd_entry = 1'b1;
                end
            end
            S_ENTRY:
            begin
                cmd.do_read = !sts.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/mrq_datapath.sv =====
// Datapath of the multi-reader ring queue block: configuration registers, queue,
// entry and last-seen memories, slot remainder unit and result register.
// Depends on mrq_pkg and mrq_ram.
module mrq_datapath import mrq_pkg::*; #(
    parameter int NUM_QUEUES    = NUM_QUEUES_DEF,
    parameter int MAX_DEPTH     = MAX_DEPTH_DEF,
    parameter int MAX_CONSUMERS = MAX_CONSUMERS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [FUNC_W-1:0]      func,
    input  logic [QIDX_W-1:0]      queue_index,
    input  logic [CIDX_W-1:0]      consumer_index,
    input  logic [SEQ_W-1:0]       seq_value,
    input  mrq_cmd_t               cmd,
    output mrq_sts_t               sts,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [STATUS_W-1:0]    status,
    output logic [SEQ_W-1:0]       seq_out,
    output logic [RC_W-1:0]        read_count,
    output logic                   removed,
    output logic [FILL_OUT_W-1:0]  queue_fill
);

    localparam int Q_W      = NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1;
    localparam int HEAD_W   = MAX_DEPTH > 1 ? $clog2(MAX_DEPTH) : 1;
    localparam int FILL_W   = $clog2(MAX_DEPTH + 1);
    localparam int SUM_W    = $clog2(2 * MAX_DEPTH) > 0 ? $clog2(2 * MAX_DEPTH) : 1;
    localparam int MCNT_W   = $clog2(SUM_W + 1);
    localparam int QR_W     = HEAD_W + FILL_W;
    localparam int LS_DEPTH = NUM_QUEUES * MAX_CONSUMERS;
    localparam int LS_AW    = LS_DEPTH > 1 ? $clog2(LS_DEPTH) : 1;
    localparam int LS_W     = SEQ_W + 1;
    localparam int EN_DEPTH = NUM_QUEUES * MAX_DEPTH;
    localparam int EN_AW    = EN_DEPTH > 1 ? $clog2(EN_DEPTH) : 1;
    localparam int EN_W     = SEQ_W + RC_W;

    logic [CONS_CFG_W-1:0]  cons_reg, cons_next;
    logic [DEPTH_CFG_W-1:0] depth_reg, depth_next;
    logic                   halted_reg, halted_next;
    logic [LS_AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [MCNT_W-1:0]      mod_cnt_reg, mod_cnt_next;
    logic [SUM_W-1:0]       mod_val_reg, mod_val_next;
    logic [SUM_W-1:0]       mod_rem_reg, mod_rem_next;
    logic [HEAD_W-1:0]      slot_reg, slot_next;
    logic [FUNC_W-1:0]      func_reg, func_next;
    logic [Q_W-1:0]         q_reg, q_next;
    logic [CIDX_W-1:0]      c_reg, c_next;
    logic [SEQ_W-1:0]       seq_reg, seq_next;
    logic                   res_valid_reg, res_valid_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [SEQ_W-1:0]       res_seq_reg, res_seq_next;
    logic [RC_W-1:0]        res_rc_reg, res_rc_next;
    logic                   res_removed_reg, res_removed_next;
    logic [FILL_OUT_W-1:0]  res_fill_reg, res_fill_next;

    int                     q_v;
    int                     c_v;
    int                     dep_v;
    int                     cons_v;
    logic [FILL_W-1:0]      depth_eff;
    logic [RC_W-1:0]        cons_eff;

    logic [QR_W-1:0]        q_rdata, q_wdata;
    logic [Q_W-1:0]         q_raddr, q_waddr;
    logic                   q_we;
    logic [LS_W-1:0]        ls_rdata, ls_wdata;
    logic [LS_AW-1:0]       ls_raddr, ls_waddr;
    logic                   ls_we;
    logic [EN_W-1:0]        en_rdata, en_wdata;
    logic [EN_AW-1:0]       en_raddr, en_waddr, en_push_addr, en_read_addr;
    logic                   en_we;

    logic [HEAD_W-1:0]      q_head;
    logic [FILL_W-1:0]      q_fill;
    logic [FILL_W-1:0]      fill_inc;
    logic                   is_push;
    logic                   is_stop;
    logic [SUM_W-1:0]       sum_a;
    logic [SUM_W-1:0]       sum_d;
    logic [SUM_W-1:0]       sum_sub;
    logic [HEAD_W-1:0]      slot_fast;
    logic                   needs_long;
    logic [HEAD_W-1:0]      slot_sel;
    logic [SUM_W-1:0]       rem_sh;

    logic [SEQ_W-1:0]       en_seq;
    logic [RC_W-1:0]        en_reads;
    logic [RC_W-1:0]        reads_n;
    logic                   seen;
    logic                   pop;
    logic                   new_read;
    logic [FILL_W-1:0]      slot_inc;
    logic [HEAD_W-1:0]      head_new;
    logic [FILL_W-1:0]      fill_new;
    logic [FILL_W-1:0]      res_fill_src;
    logic [31:0]            fill_wide;

    always_comb
    begin
        q_v = int'(queue_index);
        for (int i = 0; i < (1 << QIDX_W) - 1; i++)
        begin
            if (q_v >= NUM_QUEUES)
            begin
                q_v = q_v - NUM_QUEUES;
            end
        end
        c_v = int'(consumer_index);
        for (int i = 0; i < (1 << CIDX_W) - 1; i++)
        begin
            if (c_v >= MAX_CONSUMERS)
            begin
                c_v = c_v - MAX_CONSUMERS;
            end
        end
    end

    always_comb
    begin
        dep_v = int'(depth_reg);
        if (dep_v == 0)
        begin
            dep_v = 1;
        end
        else if (dep_v > MAX_DEPTH)
        begin
            dep_v = MAX_DEPTH;
        end
        cons_v = int'(cons_reg);
        if (cons_v == 0)
        begin
            cons_v = 1;
        end
        else if (cons_v > MAX_CONSUMERS)
        begin
            cons_v = MAX_CONSUMERS;
        end
        depth_eff = FILL_W'(dep_v);
        cons_eff  = RC_W'(cons_v);
    end

    assign q_head   = q_rdata[QR_W-1:FILL_W];
    assign q_fill   = q_rdata[FILL_W-1:0];
    assign fill_inc = q_fill + FILL_W'(1);
    assign is_push  = (func_reg == FUNC_PUSH);
    assign is_stop  = (func_reg != FUNC_PUSH) && (func_reg != FUNC_READ);

    always_comb
    begin
        sum_a      = SUM_W'(q_head) + (is_push ? SUM_W'(q_fill) : SUM_W'(0));
        sum_d      = SUM_W'(depth_eff);
        sum_sub    = sum_a - sum_d;
        needs_long = 1'b0;
        if (sum_a < sum_d)
        begin
            slot_fast = HEAD_W'(sum_a);
        end
        else if (sum_sub < sum_d)
        begin
            slot_fast = HEAD_W'(sum_sub);
        end
        else
        begin
            slot_fast  = '0;
            needs_long = 1'b1;
        end
    end

    assign slot_sel = cmd.slot_from_mod ? HEAD_W'(mod_rem_reg) : slot_fast;

    always_comb
    begin
        rem_sh = SUM_W'({mod_rem_reg, mod_val_reg[SUM_W-1]});
        if (rem_sh >= sum_d)
        begin
            rem_sh = rem_sh - sum_d;
        end
    end

    assign en_seq   = en_rdata[EN_W-1:RC_W];
    assign en_reads = en_rdata[RC_W-1:0];
    assign reads_n  = (&en_reads) ? en_reads : en_reads + RC_W'(1);
    assign seen     = ls_rdata[SEQ_W] && (ls_rdata[SEQ_W-1:0] == en_seq);
    assign pop      = (reads_n >= cons_eff);
    assign new_read = cmd.do_read && !seen;
    assign slot_inc = FILL_W'(slot_reg) + FILL_W'(1);
    assign head_new = pop ? ((slot_inc == depth_eff) ? '0 : HEAD_W'(slot_inc)) : q_head;
    assign fill_new = pop ? q_fill - FILL_W'(1) : q_fill;

    assign en_push_addr = EN_AW'(int'(q_reg) * MAX_DEPTH + int'(slot_sel));
    assign en_read_addr = EN_AW'(int'(q_reg) * MAX_DEPTH + int'(slot_reg));
    assign en_raddr     = en_push_addr;
    assign en_we        = cmd.do_push || new_read;
    assign en_waddr     = cmd.do_push ? en_push_addr : en_read_addr;
    assign en_wdata     = cmd.do_push ? {seq_reg, RC_W'(0)} : {en_seq, reads_n};

    assign q_raddr = Q_W'(q_v);
    assign q_we    = (cmd.clr_step && (int'(clr_cnt_reg) < NUM_QUEUES))
                     || cmd.do_push || new_read;
    assign q_waddr = cmd.clr_step ? Q_W'(clr_cnt_reg) : q_reg;

    always_comb
    begin
        if (cmd.clr_step)
        begin
            q_wdata = '0;
        end
        else if (cmd.do_push)
        begin
            q_wdata = {q_head, fill_inc};
        end
        else
        begin
            q_wdata = {head_new, fill_new};
        end
    end

    assign ls_raddr = LS_AW'(q_v * MAX_CONSUMERS + c_v);
    assign ls_we    = cmd.clr_step || new_read;
    assign ls_waddr = cmd.clr_step ? clr_cnt_reg
                                   : LS_AW'(int'(q_reg) * MAX_CONSUMERS + int'(c_reg));
    assign ls_wdata = cmd.clr_step ? '0 : {1'b1, en_seq};

    mrq_ram #(.WIDTH(QR_W), .DEPTH(NUM_QUEUES)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (cmd.accept),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    mrq_ram #(.WIDTH(LS_W), .DEPTH(LS_DEPTH)) u_seen_ram (
        .clk   (clk),
        .we    (ls_we),
        .waddr (ls_waddr),
        .wdata (ls_wdata),
        .re    (cmd.accept),
        .raddr (ls_raddr),
        .rdata (ls_rdata)
    );

    mrq_ram #(.WIDTH(EN_W), .DEPTH(EN_DEPTH)) u_entry_ram (
        .clk   (clk),
        .we    (en_we),
        .waddr (en_waddr),
        .wdata (en_wdata),
        .re    (cmd.rd_entry),
        .raddr (en_raddr),
        .rdata (en_rdata)
    );

    always_comb
    begin
        cons_next  = cons_reg;
        depth_next = depth_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_CONSUMERS: cons_next  = cfg_data[CONS_CFG_W-1:0];
                CFG_DEPTH:     depth_next = cfg_data[DEPTH_CFG_W-1:0];
                default:       cons_next  = cons_reg;
            endcase
        end
    end

    always_comb
    begin
        halted_next  = halted_reg || (cmd.do_fail && (is_stop || is_push));
        clr_cnt_next = cmd.clr_step ? clr_cnt_reg + LS_AW'(1) : clr_cnt_reg;
        mod_cnt_next = mod_cnt_reg;
        mod_val_next = mod_val_reg;
        mod_rem_next = mod_rem_reg;
        if (cmd.mod_start)
        begin
            mod_cnt_next = MCNT_W'(SUM_W);
            mod_val_next = sum_a;
            mod_rem_next = '0;
        end
        else if (cmd.mod_step)
        begin
            mod_cnt_next = mod_cnt_reg - MCNT_W'(1);
            mod_val_next = mod_val_reg << 1;
            mod_rem_next = rem_sh;
        end
        slot_next = cmd.rd_entry ? slot_sel : slot_reg;
        func_next = cmd.accept ? func : func_reg;
        q_next    = cmd.accept ? Q_W'(q_v) : q_reg;
        c_next    = cmd.accept ? CIDX_W'(c_v) : c_reg;
        seq_next  = cmd.accept ? seq_value : seq_reg;
    end

    always_comb
    begin
        res_valid_next   = res_valid_reg && !result_ready;
        res_status_next  = res_status_reg;
        res_seq_next     = res_seq_reg;
        res_rc_next      = res_rc_reg;
        res_removed_next = res_removed_reg;
        res_fill_src     = q_fill;
        if (cmd.do_fail)
        begin
            res_valid_next   = 1'b1;
            res_seq_next     = '0;
            res_rc_next      = '0;
            res_removed_next = 1'b0;
            if (halted_reg)
            begin
                res_status_next = ST_HALTED;
            end
            else if (is_stop)
            begin
                res_status_next = ST_STOPPED;
            end
            else if (is_push)
            begin
                res_status_next = ST_OVERFLOW;
            end
            else
            begin
                res_status_next = ST_EMPTY;
            end
        end
        else if (cmd.do_push)
        begin
            res_valid_next   = 1'b1;
            res_status_next  = ST_PUSHED;
            res_seq_next     = '0;
            res_rc_next      = '0;
            res_removed_next = 1'b0;
            res_fill_src     = fill_inc;
        end
        else if (cmd.do_read)
        begin
            res_valid_next = 1'b1;
            res_seq_next   = en_seq;
            if (seen)
            begin
                res_status_next  = ST_ALREADY;
                res_rc_next      = en_reads;
                res_removed_next = 1'b0;
            end
            else
            begin
                res_status_next  = ST_READ_NEW;
                res_rc_next      = reads_n;
                res_removed_next = pop;
                res_fill_src     = fill_new;
            end
        end
        fill_wide     = 32'(res_fill_src);
        res_fill_next = (cmd.do_fail || cmd.do_push || cmd.do_read)
                        ? fill_wide[FILL_OUT_W-1:0] : res_fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cons_reg      <= CONS_RESET;
            depth_reg     <= DEPTH_RESET;
            halted_reg    <= 1'b0;
            clr_cnt_reg   <= '0;
            mod_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cons_reg      <= cons_next;
            depth_reg     <= depth_next;
            halted_reg    <= halted_next;
            clr_cnt_reg   <= clr_cnt_next;
            mod_cnt_reg   <= mod_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mod_val_reg     <= mod_val_next;
        mod_rem_reg     <= mod_rem_next;
        slot_reg        <= slot_next;
        func_reg        <= func_next;
        q_reg           <= q_next;
        c_reg           <= c_next;
        seq_reg         <= seq_next;
        res_status_reg  <= res_status_next;
        res_seq_reg     <= res_seq_next;
        res_rc_reg      <= res_rc_next;
        res_removed_reg <= res_removed_next;
        res_fill_reg    <= res_fill_next;
    end

    assign sts.halted     = halted_reg;
    assign sts.is_push    = is_push;
    assign sts.is_stop    = is_stop;
    assign sts.full       = (q_fill >= depth_eff);
    assign sts.empty      = (q_fill == '0);
    assign sts.needs_long = needs_long;
    assign sts.mod_done   = (mod_cnt_reg == MCNT_W'(1));
    assign sts.out_busy   = res_valid_reg && !result_ready;
    assign sts.clear_done = (int'(clr_cnt_reg) == LS_DEPTH - 1);

    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign seq_out      = res_seq_reg;
    assign read_count   = res_rc_reg;
    assign removed      = res_removed_reg;
    assign queue_fill   = res_fill_reg;

endmodule

// ===== rtl/multi_reader_ring_queues_top.sv =====
// Channel   Direction  Handshake          Payload
// item      in         valid/ready        func, queue_index, consumer_index, seq_value
// result    out        valid/ready        status, seq_out, read_count, removed, queue_fill
// cfg       in         cfg_wr_en only     cfg_index, cfg_data
//
// A push, stop, overflow, empty read or halted item is finished in S_LOOKUP; a read
// of a non-empty queue goes on to S_ENTRY, owing to the registered RAM reads.
// When a queue's head, or for a push its tail, lies at or beyond twice the reduced
// depth, the slot remainder unit steps in S_MOD, one quotient bit per cycle.
// After reset the last-seen and queue RAMs are cleared in S_CLEAR, while no item is
// accepted. A stalled result holds the block before it commits any state change of
// the next item.
module multi_reader_ring_queues_top import mrq_pkg::*; #(
    parameter int NUM_QUEUES    = NUM_QUEUES_DEF,
    parameter int MAX_DEPTH     = MAX_DEPTH_DEF,
    parameter int MAX_CONSUMERS = MAX_CONSUMERS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mrq_item_if.sink              item,
    mrq_result_if.source          result
);

    mrq_cmd_t cmd;
    mrq_sts_t sts;

    mrq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    mrq_datapath #(
        .NUM_QUEUES    (NUM_QUEUES),
        .MAX_DEPTH     (MAX_DEPTH),
        .MAX_CONSUMERS (MAX_CONSUMERS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .func           (item.func),
        .queue_index    (item.queue_index),
        .consumer_index (item.consumer_index),
        .seq_value      (item.seq_value),
        .cmd            (cmd),
        .sts            (sts),
        .result_valid   (result.valid),
        .result_ready   (result.ready),
        .status         (result.status),
        .seq_out        (result.seq_out),
        .read_count     (result.read_count),
        .removed        (result.removed),
        .queue_fill     (result.queue_fill)
    );

`ifndef NO_ASSERTIONS
    // Only one transaction is in flight at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !item.ready)
        else $error("item accepted while another one is in flight");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_push || cmd.do_fail || cmd.do_read |=> result.valid)
        else $error("finished transaction did not reach the result register");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.rd_entry, cmd.do_push, cmd.do_fail,
                  cmd.do_read, cmd.mod_start, cmd.clr_step}))
        else $error("conflicting controller commands");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !item.ready)
        else $error("item accepted during the clearing pass");
`endif

endmodule
